FILE: hdl/slt_pkg.sv
package slt_pkg;

  // lexer modes
  typedef enum logic [3:0] {
    M_BETWEEN,
    M_WORD,
    M_WORD_ESC,
    M_QUOTE,
    M_QUOTE_ESC,
    M_SEP_AMP,
    M_SEP_LT,
    M_SEP_GT,
    M_SEP_GGT,
    M_DROP
  } mode_t;

  // result kinds
  localparam logic [2:0] K_CHAR = 3'd0;
  localparam logic [2:0] K_WEND = 3'd1;
  localparam logic [2:0] K_AMP  = 3'd2;
  localparam logic [2:0] K_LT   = 3'd3;
  localparam logic [2:0] K_GT   = 3'd4;
  localparam logic [2:0] K_GGT  = 3'd5;
  localparam logic [2:0] K_EOL  = 3'd6;
  localparam logic [2:0] K_ERR  = 3'd7;

  // error codes
  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_SEP   = 2'd0;
  localparam logic [1:0] E_QUOTE = 2'd1;
  localparam logic [1:0] E_ESC   = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_BSL = 8'h5C;

  // request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [1:0] err;
  } result_t;

  // one request: one or two results caused by a single byte
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_GT) || (c == CH_AMP) || (c == CH_LT);
  endfunction

  // mode after a byte seen between tokens
  function automatic mode_t btw_mode(input logic [7:0] c);
    mode_t m;
    if (c == CH_NUL || is_space(c)) m = M_BETWEEN;
    else if (c == CH_AMP) m = M_SEP_AMP;
    else if (c == CH_LT) m = M_SEP_LT;
    else if (c == CH_GT) m = M_SEP_GT;
    else if (c == CH_BSL) m = M_WORD_ESC;
    else if (c == CH_DQ) m = M_QUOTE;
    else m = M_WORD;
    return m;
  endfunction

  function automatic logic btw_emit(input logic [7:0] c);
    return (c == CH_NUL) ||
           !(is_space(c) || is_sep(c) || c == CH_BSL || c == CH_DQ);
  endfunction

  function automatic result_t btw_res(input logic [7:0] c);
    result_t r;
    r.err = E_NONE;
    if (c == CH_NUL) begin
      r.kind = K_EOL;
      r.ch   = 8'd0;
    end else begin
      r.kind = K_CHAR;
      r.ch   = c;
    end
    return r;
  endfunction

  function automatic result_t mk_res(input logic [2:0] kind, input logic [7:0] ch,
                                     input logic [1:0] err);
    result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.err  = err;
    return r;
  endfunction

endpackage

FILE: hdl/slt_front.sv
module slt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  slt_pkg::q_stat_t q_stat,
  output logic           push,
  output slt_pkg::entry_t push_entry
);
  import slt_pkg::*;

  mode_t   mode, mode_next;
  entry_t  ent;
  logic    ent_valid;
  logic    accept;
  logic    word_end;
  logic [2:0] tok_kind;

  assign in_stall   = q_stat.full;
  assign accept     = in_valid && !q_stat.full;
  assign push       = accept && ent_valid;
  assign push_entry = ent;

  assign word_end = (in_byte == CH_NUL) || is_space(in_byte) || is_sep(in_byte);

  always_comb begin
    case (mode)
      M_SEP_AMP: tok_kind = K_AMP;
      M_SEP_LT:  tok_kind = K_LT;
      M_SEP_GT:  tok_kind = K_GT;
      default:   tok_kind = K_GGT;
    endcase
  end

  // next state
  always_comb begin
    case (mode)
      M_WORD: begin
        if (in_byte == CH_BSL) mode_next = M_WORD_ESC;
        else if (in_byte == CH_DQ) mode_next = M_QUOTE;
        else if (word_end) mode_next = btw_mode(in_byte);
        else mode_next = M_WORD;
      end
      M_WORD_ESC: begin
        mode_next = (in_byte == CH_NUL) ? M_BETWEEN : M_WORD;
      end
      M_QUOTE: begin
        if (in_byte == CH_NUL) mode_next = M_BETWEEN;
        else if (in_byte == CH_BSL) mode_next = M_QUOTE_ESC;
        else if (in_byte == CH_DQ) mode_next = M_WORD;
        else mode_next = M_QUOTE;
      end
      M_QUOTE_ESC: begin
        mode_next = (in_byte == CH_NUL) ? M_BETWEEN : M_QUOTE;
      end
      M_SEP_AMP, M_SEP_LT, M_SEP_GT, M_SEP_GGT: begin
        if (is_sep(in_byte)) begin
          mode_next = (mode == M_SEP_GT && in_byte == CH_GT) ? M_SEP_GGT : M_DROP;
        end else begin
          mode_next = btw_mode(in_byte);
        end
      end
      M_DROP: begin
        mode_next = (in_byte == CH_NUL) ? M_BETWEEN : M_DROP;
      end
      default: begin
        mode_next = btw_mode(in_byte);
      end
    endcase
  end

  // outputs: results caused by this byte
  always_comb begin
    ent       = '0;
    ent_valid = 1'b0;
    case (mode)
      M_WORD: begin
        if (in_byte == CH_BSL || in_byte == CH_DQ) begin
          ent_valid = 1'b0;
        end else if (word_end) begin
          ent_valid = 1'b1;
          ent.r0    = mk_res(K_WEND, 8'd0, E_NONE);
          ent.r1    = btw_res(in_byte);
          ent.two   = btw_emit(in_byte);
        end else begin
          ent_valid = 1'b1;
          ent.r0    = mk_res(K_CHAR, in_byte, E_NONE);
        end
      end
      M_WORD_ESC, M_QUOTE_ESC: begin
        ent_valid = 1'b1;
        if (in_byte == CH_NUL) ent.r0 = mk_res(K_ERR, 8'd0, E_ESC);
        else ent.r0 = mk_res(K_CHAR, in_byte, E_NONE);
      end
      M_QUOTE: begin
        if (in_byte == CH_NUL) begin
          ent_valid = 1'b1;
          ent.r0    = mk_res(K_ERR, 8'd0, E_QUOTE);
        end else if (in_byte != CH_BSL && in_byte != CH_DQ) begin
          ent_valid = 1'b1;
          ent.r0    = mk_res(K_CHAR, in_byte, E_NONE);
        end
      end
      M_SEP_AMP, M_SEP_LT, M_SEP_GT, M_SEP_GGT: begin
        if (is_sep(in_byte)) begin
          if (!(mode == M_SEP_GT && in_byte == CH_GT)) begin
            ent_valid = 1'b1;
            ent.r0    = mk_res(K_ERR, 8'd0, E_SEP);
          end
        end else begin
          ent_valid = 1'b1;
          ent.r0    = mk_res(tok_kind, 8'd0, E_NONE);
          ent.r1    = btw_res(in_byte);
          ent.two   = btw_emit(in_byte);
        end
      end
      M_DROP: begin
        ent_valid = 1'b0;
      end
      default: begin
        ent_valid = btw_emit(in_byte);
        ent.r0    = btw_res(in_byte);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_BETWEEN;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

FILE: hdl/slt_queue.sv
module slt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  slt_pkg::entry_t  push_entry,
  input  logic             pop,
  output slt_pkg::q_stat_t q_stat,
  output slt_pkg::entry_t  head
);
  import slt_pkg::*;

  entry_t           mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QCW-1:0]   count;
  logic             do_push, do_pop;

  assign q_stat.full  = (count == QCW'(QDEPTH));
  assign q_stat.valid = (count != '0);
  assign head         = mem[rd_ptr];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && q_stat.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

FILE: hdl/slt_back.sv
module slt_back (
  input  logic             clk,
  input  logic             rst,
  input  slt_pkg::q_stat_t q_stat,
  input  slt_pkg::entry_t  head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       kind,
  output logic [7:0]       char_value,
  output logic [1:0]       error_code,
  output logic             last
);
  import slt_pkg::*;

  logic    sub;    // serving second result of head request
  logic    load;
  result_t sel;

  assign load = q_stat.valid && (!out_valid || !out_stall);
  assign pop  = load && (sub || !head.two);
  assign sel  = sub ? head.r1 : head.r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= !sub && head.two;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= sel.kind;
      char_value <= sel.ch;
      error_code <= sel.err;
      last       <= sub || !head.two;
    end
  end

endmodule

FILE: hdl/shell_line_tokenizer.sv
// Channel | Handshake            | Payload                              | Dir
// in      | in_valid / in_stall  | in_byte[7:0]                         | in
// out     | out_valid / out_stall| kind[2:0] char_value[7:0]            | out
//         |                      | error_code[1:0] last                 |
//
// One byte per cycle while the 4-deep request queue has room. A NUL ending a
// word, or a NUL or word char ending a separator run, gives two results, which
// leave the output one after the other; the queue absorbs these bursts.
// Results enter the queue as their byte is taken, then the output register.
// Reset (rst, synchronous): lexer back between tokens, queue and output empty.
// in_stall rises only when the queue is full; out_stall only holds the output.
module shell_line_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [7:0] char_value,
  output logic [1:0] error_code,
  output logic       last
);
  import slt_pkg::*;

  q_stat_t q_stat;
  entry_t  push_entry;
  entry_t  head;
  logic    push;
  logic    pop;

  // front: lexer mode machine, builds one request per byte with results
  slt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // request queue
  slt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_stat     (q_stat),
    .head       (head)
  );

  // back: walks each request's results into the output register
  slt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .char_value (char_value),
    .error_code (error_code),
    .last       (last)
  );

  // back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.valid)
    else $error("pop from empty request queue");

  // second result of a request follows right after the first is taken
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("second result of a request missing");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != K_CHAR) |-> (char_value == 8'd0))
    else $error("char_value set on non-character result");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != K_ERR) |-> (error_code == E_NONE))
    else $error("error_code set on non-error result");

endmodule
